/* design/qpc_pkg.sv */
// qpc_pkg: shared types and constants of the quaternion pose composer
// default field widths, control register indexes and cross product axis tables
// no dependencies
package qpc_pkg;

   // default field widths
   localparam int DEF_POSITION_BITS = 32;
   localparam int DEF_QUAT_BITS     = 16;

   // control register index width and codes
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_POS_X  = 3'd0,
      CSR_REF_POS_Y  = 3'd1,
      CSR_REF_POS_Z  = 3'd2,
      CSR_REF_QUAT_W = 3'd3,
      CSR_REF_QUAT_X = 3'd4,
      CSR_REF_QUAT_Y = 3'd5,
      CSR_REF_QUAT_Z = 3'd6
   } csr_reg_type;

   // cross product o[i] = a[NXT[i]] * b[PRV[i]] - a[PRV[i]] * b[NXT[i]]
   localparam int AXIS_NXT [3] = '{1, 2, 0};
   localparam int AXIS_PRV [3] = '{2, 0, 1};

endpackage

/* design/quaternion_pose_compose.sv */
// quaternion_pose_compose: rotates a relative position by the reference quaternion, adds
// the reference position and forms the Hamilton product of the two orientations
// depends on qpc_pkg
//
//   channel   ports                          direction  transfer condition
//   request   start, busy, req_rel_*         in         start high and busy low at the edge
//   response  rsp_valid, rsp_out_*           out        every edge ending a cycle with rsp_valid
//   control   csr_we, csr_index, csr_wdata   in         csr_we high at the edge
//
// one pose enters per cycle outside reset; five register stages (products, cross product
// rounding, second products, rotation rounding, offset add and saturation) lie between
// the request transfer and the result.
// busy is high only during reset; reset empties the pipeline and restores the
// reference pose to identity at the origin.
// the response side cannot stall, so the pipeline never holds.
module quaternion_pose_compose
   import qpc_pkg::*;
#(
   parameter int POSITION_BITS = DEF_POSITION_BITS,
   parameter int QUAT_BITS     = DEF_QUAT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // request
   input  logic                              start,
   output logic                              busy,
   input  logic signed [POSITION_BITS-1:0]   req_rel_pos_x,
   input  logic signed [POSITION_BITS-1:0]   req_rel_pos_y,
   input  logic signed [POSITION_BITS-1:0]   req_rel_pos_z,
   input  logic signed [QUAT_BITS-1:0]       req_rel_quat_w,
   input  logic signed [QUAT_BITS-1:0]       req_rel_quat_x,
   input  logic signed [QUAT_BITS-1:0]       req_rel_quat_y,
   input  logic signed [QUAT_BITS-1:0]       req_rel_quat_z,
   // response
   output logic                              rsp_valid,
   output logic signed [POSITION_BITS-1:0]   rsp_out_pos_x,
   output logic signed [POSITION_BITS-1:0]   rsp_out_pos_y,
   output logic signed [POSITION_BITS-1:0]   rsp_out_pos_z,
   output logic signed [QUAT_BITS-1:0]       rsp_out_quat_w,
   output logic signed [QUAT_BITS-1:0]       rsp_out_quat_x,
   output logic signed [QUAT_BITS-1:0]       rsp_out_quat_y,
   output logic signed [QUAT_BITS-1:0]       rsp_out_quat_z,
   // control registers
   input  logic                              csr_we,
   input  logic [CSR_IDX_W-1:0]              csr_index,
   input  logic [(POSITION_BITS > QUAT_BITS ? POSITION_BITS : QUAT_BITS)-1:0] csr_wdata
);

   // fraction bits of a quaternion component
   localparam int F    = QUAT_BITS - 2;
   // first cross product, full precision
   localparam int UVW  = POSITION_BITS + QUAT_BITS;
   localparam int CW   = UVW + 1;
   // first cross product rounded back to position scale
   localparam int C16W = CW - F + 1;
   // second products and their sum
   localparam int EW   = QUAT_BITS + C16W;
   localparam int DW   = EW + 2;
   // rotation offset after rounding
   localparam int RSW  = DW - F + 2;
   // final position sum
   localparam int SW   = (RSW > POSITION_BITS ? RSW : POSITION_BITS) + 2;
   // quaternion products, sums and rounded sums
   localparam int QPW  = 2 * QUAT_BITS;
   localparam int QSW  = QPW + 2;
   localparam int QRW  = QSW - F + 1;
   localparam int STAGES = 5;

   localparam logic signed [CW:0]  C_HALF = (CW + 1)'(1) << (F - 1);
   localparam logic signed [DW:0]  D_HALF = (DW + 1)'(1) << (F - 2);
   localparam logic signed [QSW:0] Q_HALF = (QSW + 1)'(1) << (F - 1);
   localparam logic signed [SW-1:0]  POS_MAX = SW'($signed({1'b0, {(POSITION_BITS-1){1'b1}}}));
   localparam logic signed [SW-1:0]  POS_MIN = SW'($signed({1'b1, {(POSITION_BITS-1){1'b0}}}));
   localparam logic signed [QRW-1:0] QUAT_MAX = QRW'($signed({2'b01, {F{1'b0}}}));
   localparam logic signed [QRW-1:0] QUAT_MIN = -QUAT_MAX;
   localparam logic signed [QUAT_BITS-1:0] QUAT_ONE = QUAT_BITS'($signed({2'b01, {F{1'b0}}}));

   // reference pose registers: position x,y,z and quaternion w,x,y,z
   logic signed [POSITION_BITS-1:0] ref_pos_ff  [3];
   logic signed [QUAT_BITS-1:0]     ref_quat_ff [4];
   logic [STAGES-1:0]               vld_ff;
   logic [STAGES-1:0]               vld_in;
   logic                            accept;

   // request fields gathered into arrays
   logic signed [POSITION_BITS-1:0] rel_pos  [3];
   logic signed [QUAT_BITS-1:0]     rel_quat [4];

   // stage 1: products
   logic signed [UVW-1:0]           uv_a_ff [3];
   logic signed [UVW-1:0]           uv_b_ff [3];
   logic signed [QPW-1:0]           qp_ff   [4][4];
   logic signed [POSITION_BITS-1:0] v1_ff   [3];
   // stage 2: rounded cross product and quaternion sums
   logic signed [C16W-1:0]          c16_in  [3];
   logic signed [C16W-1:0]          c16_ff  [3];
   logic signed [QSW-1:0]           qs_in   [4];
   logic signed [QSW-1:0]           qs_ff   [4];
   logic signed [POSITION_BITS-1:0] v2_ff   [3];
   // stage 3: second products and saturated quaternion
   logic signed [EW-1:0]            wc_ff   [3];
   logic signed [EW-1:0]            ea_ff   [3];
   logic signed [EW-1:0]            eb_ff   [3];
   logic signed [QUAT_BITS-1:0]     qo_in   [4];
   logic signed [QUAT_BITS-1:0]     qo3_ff  [4];
   logic signed [POSITION_BITS-1:0] v3_ff   [3];
   // stage 4: rounded rotation offset
   logic signed [RSW-1:0]           rs_in   [3];
   logic signed [RSW-1:0]           rs_ff   [3];
   logic signed [QUAT_BITS-1:0]     qo4_ff  [4];
   logic signed [POSITION_BITS-1:0] v4_ff   [3];
   // stage 5: outputs
   logic signed [POSITION_BITS-1:0] po_in   [3];
   logic signed [POSITION_BITS-1:0] po_ff   [3];
   logic signed [QUAT_BITS-1:0]     qo5_ff  [4];

   // request handshake
   assign busy   = reset;
   assign accept = start & ~busy;
   assign vld_in = {vld_ff[STAGES-2:0], accept};

   assign rel_pos[0]  = req_rel_pos_x;
   assign rel_pos[1]  = req_rel_pos_y;
   assign rel_pos[2]  = req_rel_pos_z;
   assign rel_quat[0] = req_rel_quat_w;
   assign rel_quat[1] = req_rel_quat_x;
   assign rel_quat[2] = req_rel_quat_y;
   assign rel_quat[3] = req_rel_quat_z;

   // control registers and valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            ref_pos_ff[i] <= '0;
         end
         ref_quat_ff[0] <= QUAT_ONE;
         for (int i = 1; i < 4; i++) begin
            ref_quat_ff[i] <= '0;
         end
      end else begin
         vld_ff <= vld_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_REF_POS_X:  ref_pos_ff[0]  <= csr_wdata[POSITION_BITS-1:0];
               CSR_REF_POS_Y:  ref_pos_ff[1]  <= csr_wdata[POSITION_BITS-1:0];
               CSR_REF_POS_Z:  ref_pos_ff[2]  <= csr_wdata[POSITION_BITS-1:0];
               CSR_REF_QUAT_W: ref_quat_ff[0] <= csr_wdata[QUAT_BITS-1:0];
               CSR_REF_QUAT_X: ref_quat_ff[1] <= csr_wdata[QUAT_BITS-1:0];
               CSR_REF_QUAT_Y: ref_quat_ff[2] <= csr_wdata[QUAT_BITS-1:0];
               CSR_REF_QUAT_Z: ref_quat_ff[3] <= csr_wdata[QUAT_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   // stage 2 logic: cross product difference rounded to position scale
   always_comb begin
      logic signed [CW-1:0] diff;
      logic signed [CW:0]   tmp;
      for (int i = 0; i < 3; i++) begin
         diff      = CW'(uv_a_ff[i]) - CW'(uv_b_ff[i]);
         tmp       = (CW + 1)'(diff) + C_HALF - (CW + 1)'(diff[CW-1]);
         c16_in[i] = tmp[CW:F];
      end
   end

   // stage 2 logic: Hamilton product sums
   always_comb begin
      qs_in[0] = QSW'(qp_ff[0][0]) - QSW'(qp_ff[1][1]) - QSW'(qp_ff[2][2]) - QSW'(qp_ff[3][3]);
      qs_in[1] = QSW'(qp_ff[0][1]) + QSW'(qp_ff[1][0]) + QSW'(qp_ff[2][3]) - QSW'(qp_ff[3][2]);
      qs_in[2] = QSW'(qp_ff[0][2]) - QSW'(qp_ff[1][3]) + QSW'(qp_ff[2][0]) + QSW'(qp_ff[3][1]);
      qs_in[3] = QSW'(qp_ff[0][3]) + QSW'(qp_ff[1][2]) - QSW'(qp_ff[2][1]) + QSW'(qp_ff[3][0]);
   end

   // stage 3 logic: quaternion rounding and saturation
   always_comb begin
      logic signed [QSW:0]    tmp;
      logic signed [QRW-1:0]  rnd;
      logic signed [QRW-1:0]  sat;
      for (int k = 0; k < 4; k++) begin
         tmp = (QSW + 1)'(qs_ff[k]) + Q_HALF - (QSW + 1)'(qs_ff[k][QSW-1]);
         rnd = tmp[QSW:F];
         if (rnd > QUAT_MAX) begin
            sat = QUAT_MAX;
         end else if (rnd < QUAT_MIN) begin
            sat = QUAT_MIN;
         end else begin
            sat = rnd;
         end
         qo_in[k] = sat[QUAT_BITS-1:0];
      end
   end

   // stage 4 logic: d = w*c16 + u x c16, then 2d rounded back to position scale
   always_comb begin
      logic signed [DW-1:0] d;
      logic signed [DW:0]   tmp;
      for (int i = 0; i < 3; i++) begin
         d        = DW'(wc_ff[i]) + DW'(ea_ff[i]) - DW'(eb_ff[i]);
         tmp      = (DW + 1)'(d) + D_HALF - (DW + 1)'(d[DW-1]);
         rs_in[i] = tmp[DW:F-1];
      end
   end

   // stage 5 logic: add relative position, rotation offset and reference position, saturate
   always_comb begin
      logic signed [SW-1:0] sum;
      for (int i = 0; i < 3; i++) begin
         sum = SW'(v4_ff[i]) + SW'(rs_ff[i]) + SW'(ref_pos_ff[i]);
         if (sum > POS_MAX) begin
            sum = POS_MAX;
         end else if (sum < POS_MIN) begin
            sum = POS_MIN;
         end
         po_in[i] = sum[POSITION_BITS-1:0];
      end
   end

   // pipeline payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         // stage 1
         uv_a_ff[i] <= UVW'(ref_quat_ff[1 + AXIS_NXT[i]]) * UVW'(rel_pos[AXIS_PRV[i]]);
         uv_b_ff[i] <= UVW'(ref_quat_ff[1 + AXIS_PRV[i]]) * UVW'(rel_pos[AXIS_NXT[i]]);
         v1_ff[i]   <= rel_pos[i];
         // stage 2
         c16_ff[i]  <= c16_in[i];
         v2_ff[i]   <= v1_ff[i];
         // stage 3
         wc_ff[i]   <= EW'(ref_quat_ff[0]) * EW'(c16_ff[i]);
         ea_ff[i]   <= EW'(ref_quat_ff[1 + AXIS_NXT[i]]) * EW'(c16_ff[AXIS_PRV[i]]);
         eb_ff[i]   <= EW'(ref_quat_ff[1 + AXIS_PRV[i]]) * EW'(c16_ff[AXIS_NXT[i]]);
         v3_ff[i]   <= v2_ff[i];
         // stage 4
         rs_ff[i]   <= rs_in[i];
         v4_ff[i]   <= v3_ff[i];
         // stage 5
         po_ff[i]   <= po_in[i];
      end
      for (int k = 0; k < 4; k++) begin
         for (int j = 0; j < 4; j++) begin
            qp_ff[k][j] <= QPW'(ref_quat_ff[k]) * QPW'(rel_quat[j]);
         end
         qs_ff[k]  <= qs_in[k];
         qo3_ff[k] <= qo_in[k];
         qo4_ff[k] <= qo3_ff[k];
         qo5_ff[k] <= qo4_ff[k];
      end
   end

   // response ports
   assign rsp_valid      = vld_ff[STAGES-1];
   assign rsp_out_pos_x  = po_ff[0];
   assign rsp_out_pos_y  = po_ff[1];
   assign rsp_out_pos_z  = po_ff[2];
   assign rsp_out_quat_w = qo5_ff[0];
   assign rsp_out_quat_x = qo5_ff[1];
   assign rsp_out_quat_y = qo5_ff[2];
   assign rsp_out_quat_z = qo5_ff[3];

   // every request transfer yields a response from the last stage of the valid chain
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("response missing after request transfer");

   // reset empties the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid && vld_ff == '0)
      else $error("pipeline not empty after reset");

   // a response needs a matching earlier request transfer
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("response without matching request");

   // w and z of the composed orientation stay within unit range
   a_quat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (QRW'(rsp_out_quat_w) <= QUAT_MAX) && (QRW'(rsp_out_quat_w) >= QUAT_MIN)
         && (QRW'(rsp_out_quat_z) <= QUAT_MAX) && (QRW'(rsp_out_quat_z) >= QUAT_MIN))
      else $error("composed quaternion out of range");

endmodule
